@@ hdl/blzd_pkg.sv @@
// Shared types and constants of the block LZ decompressor.
`default_nettype none
package blzd_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int COUNT_W = 24;
	localparam int DIST_W = 12;
	localparam int LEN_W = 5;
	localparam int HDR_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
	localparam logic [15:0] DIST_MASK = 16'hFFF0;
	localparam logic [15:0] LEN_MASK = 16'h000F;
	localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
	localparam int RAW_BIT = 7;

	// Header byte positions.
	localparam logic [HDR_IDX_W-1:0] HDR_SIZE_LO = 2'd0;
	localparam logic [HDR_IDX_W-1:0] HDR_SIZE_MID = 2'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_SIZE_HI = 2'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_MODE = 2'd3;

	typedef enum logic [3:0] {
		ST_HEADER,
		ST_MASK_LO,
		ST_MASK_HI,
		ST_TOKEN,
		ST_REF_HI,
		ST_RAW,
		ST_DONE,
		ST_COPY_RD,
		ST_COPY_WR
	} blzd_state_t;

	typedef struct packed {
		logic restart;
		logic hdr_load;
		logic mask_lo_load;
		logic mask_hi_load;
		logic lit_emit;
		logic lit_chk;
		logic bit_adv;
		logic ref_lo_load;
		logic ref_start;
		logic copy_rd;
		logic copy_emit;
	} blzd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic hdr_last;
		logic raw_bit;
		logic mask_bit;
		logic bit_last;
		logic copy_last;
		logic reached;
	} blzd_sts_t;

endpackage
`default_nettype wire

@@ hdl/blzd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module blzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/blzd_ctrl.sv @@
// Parser and copy sequencer state machine of the block LZ decompressor.
`default_nettype none
module blzd_ctrl
	import blzd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      start_block,
	output logic           in_ready,
	input  wire blzd_sts_t sts,
	output blzd_cmd_t      cmd
);

	blzd_state_t state_q, state_d, phase;
	logic        accepting, accept;
	blzd_state_t end_state;

	assign accepting = !(state_q inside {ST_COPY_RD, ST_COPY_WR});
	assign in_ready  = accepting && sts.out_free;
	assign accept    = in_valid && in_ready;
	// A start mark restarts the parser on this very item.
	assign phase     = start_block ? ST_HEADER : state_q;
	assign end_state = sts.reached ? ST_DONE : (sts.bit_last ? ST_MASK_LO : ST_TOKEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		if (accepting) begin
			if (accept) begin
				case (phase)
					ST_HEADER: begin
						if (sts.hdr_last) begin
							state_d = sts.raw_bit ? ST_RAW : ST_MASK_LO;
						end else begin
							state_d = ST_HEADER;
						end
					end
					ST_MASK_LO: state_d = ST_MASK_HI;
					ST_MASK_HI: state_d = ST_TOKEN;
					ST_TOKEN: begin
						state_d = sts.mask_bit ? ST_REF_HI : end_state;
					end
					ST_REF_HI: state_d = ST_COPY_RD;
					ST_RAW:    state_d = ST_RAW;
					ST_DONE:   state_d = ST_DONE;
					default:   state_d = state_q;
				endcase
			end
		end else begin
			case (state_q)
				ST_COPY_RD: state_d = ST_COPY_WR;
				ST_COPY_WR: begin
					if (sts.out_free) begin
						state_d = sts.copy_last ? end_state : ST_COPY_RD;
					end
				end
				default: state_d = state_q;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		if (accept) begin
			cmd.restart = start_block;
			case (phase)
				ST_HEADER:  cmd.hdr_load = 1'b1;
				ST_MASK_LO: cmd.mask_lo_load = 1'b1;
				ST_MASK_HI: cmd.mask_hi_load = 1'b1;
				ST_TOKEN: begin
					if (sts.mask_bit) begin
						cmd.ref_lo_load = 1'b1;
					end else begin
						cmd.lit_emit = 1'b1;
						cmd.lit_chk  = 1'b1;
						cmd.bit_adv  = 1'b1;
					end
				end
				ST_REF_HI: cmd.ref_start = 1'b1;
				ST_RAW:    cmd.lit_emit = 1'b1;
				default:   cmd = '0;
			endcase
		end
		case (state_q)
			ST_COPY_RD: cmd.copy_rd = 1'b1;
			ST_COPY_WR: begin
				cmd.copy_emit = sts.out_free;
				cmd.bit_adv   = sts.out_free && sts.copy_last;
			end
			default: cmd.copy_rd = 1'b0;
		endcase
	end

`ifndef SYNTHESIS
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY_RD |=> state_q == ST_COPY_WR)
		else $error("copy read not followed by copy write");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.lit_emit || cmd.copy_emit) |-> sts.out_free)
		else $error("byte emitted into an occupied output register");

	a_copy_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_emit && sts.copy_last) |=>
		(state_q != ST_COPY_RD && state_q != ST_COPY_WR))
		else $error("copy continued past its last byte");

	a_restart_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |-> (cmd.hdr_load && !cmd.lit_emit))
		else $error("restart item not taken as header byte");
`endif

endmodule
`default_nettype wire

@@ hdl/blzd_dp.sv @@
// Datapath of the block LZ decompressor: header, mask, counters, window and output register.
`default_nettype none
module blzd_dp
	import blzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire blzd_cmd_t  cmd,
	output blzd_sts_t       sts,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic      [7:0] out_byte,
	output logic            last_of_run,
	output logic            block_done
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [COUNT_W-1:0]   count_q, target_q, count_inc;
	logic [AW-1:0]        wp_q, wp_inc, raddr;
	logic [AW:0]          wp_ext, dist_ext, raddr_ext;
	logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx;
	logic [15:0]          mask_q, word;
	logic [3:0]           bit_idx_q;
	logic [7:0]           ref_lo_q, rdata, copy_byte, emit_byte;
	logic [DIST_W-1:0]    dist_m1_q;
	logic [LEN_W-1:0]     len_q;
	logic                 out_valid_q, emit, src_ok;

	assign hdr_idx   = cmd.restart ? HDR_SIZE_LO : hdr_idx_q;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
	assign wp_inc    = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign word      = {in_byte, ref_lo_q};

	// Source of a copied byte, one distance behind the write position, modulo the depth.
	assign wp_ext    = {1'b0, wp_q};
	assign dist_ext  = (AW+1)'(dist_m1_q) + (AW+1)'(1);
	assign raddr_ext = (wp_ext >= dist_ext) ? wp_ext - dist_ext
	                                        : wp_ext + (AW+1)'(WINDOW_DEPTH) - dist_ext;
	assign raddr     = raddr_ext[AW-1:0];

	// A source before the start of the block reads as zero.
	assign src_ok    = count_q > COUNT_W'(dist_m1_q);
	assign copy_byte = src_ok ? rdata : 8'h00;
	assign emit      = cmd.lit_emit || cmd.copy_emit;
	assign emit_byte = cmd.copy_emit ? copy_byte : in_byte;

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.hdr_last  = hdr_idx == HDR_MODE;
	assign sts.raw_bit   = in_byte[RAW_BIT];
	assign sts.mask_bit  = mask_q[bit_idx_q];
	assign sts.bit_last  = bit_idx_q == 4'd15;
	assign sts.copy_last = len_q == LEN_W'(1);
	assign sts.reached   = count_inc >= target_q;

	blzd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (emit),
		.waddr (wp_q),
		.wdata (emit_byte),
		.re    (cmd.copy_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			target_q    <= '0;
			wp_q        <= '0;
			hdr_idx_q   <= '0;
			mask_q      <= '0;
			bit_idx_q   <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				count_q <= '0;
				wp_q    <= '0;
			end
			if (cmd.hdr_load) begin
				hdr_idx_q <= hdr_idx + HDR_IDX_W'(1);
				case (hdr_idx)
					HDR_SIZE_LO:  target_q <= COUNT_W'(in_byte);
					HDR_SIZE_MID: target_q[15:8] <= in_byte;
					HDR_SIZE_HI:  target_q[23:16] <= in_byte;
					HDR_MODE:     target_q <= target_q;
					default:      target_q <= target_q;
				endcase
			end
			if (cmd.mask_lo_load) begin
				mask_q[7:0] <= in_byte;
			end
			if (cmd.mask_hi_load) begin
				mask_q[15:8] <= in_byte;
				bit_idx_q    <= '0;
			end
			if (cmd.bit_adv) begin
				bit_idx_q <= bit_idx_q + 4'd1;
			end
			if (cmd.ref_start) begin
				len_q <= LEN_W'(word & LEN_MASK) + LEN_BIAS;
			end else if (cmd.copy_emit) begin
				len_q <= len_q - LEN_W'(1);
			end
			if (emit) begin
				count_q <= count_inc;
				wp_q    <= wp_inc;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ref_lo_load) begin
			ref_lo_q <= in_byte;
		end
		if (cmd.ref_start) begin
			dist_m1_q <= DIST_W'((word & DIST_MASK) >> 4);
		end
		if (emit) begin
			out_byte    <= emit_byte;
			last_of_run <= cmd.lit_emit || sts.copy_last;
			block_done  <= (cmd.lit_chk || (cmd.copy_emit && sts.copy_last)) && sts.reached;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ hdl/block_lz_decompressor_core.sv @@
// A literal or raw item shows its byte on the outputs in the cycle after it is accepted.
// Header, mask and reference low-byte items give no result.
// A back-reference of length L (3 to 18) is copied after its second byte; each copied byte
// needs a window RAM read and then a write, and no input is taken while the copy runs.
// Reset (arst_n low) clears the parser and counters at once; the window RAM is not cleared.
// Top level of the block LZ decompressor.
`default_nettype none
module block_lz_decompressor_core
	import blzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       start_block,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_byte,
	output logic            last_of_run,
	output logic            block_done
);

	blzd_cmd_t cmd;
	blzd_sts_t sts;

	blzd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.start_block (start_block),
		.in_ready    (in_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	blzd_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.block_done  (block_done)
	);

endmodule
`default_nettype wire

@@ tb/blzd_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// Byte-level predictor and scoreboard for the block LZ decompressor testbench.
package blzd_scoreboard_pkg;
	import blzd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} lz_result_t;

	class lz_byte_scoreboard;
		logic [7:0]           window_mem [WINDOW_DEPTH_DEF];
		logic [DIST_W-1:0]    wr_ptr;
		logic [COUNT_W-1:0]   out_count;
		logic [COUNT_W-1:0]   size_goal;
		logic                 raw_on;
		logic [HDR_IDX_W-1:0] hdr_pos;
		logic [15:0]          flag_mask;
		logic [4:0]           flag_pos;
		blzd_state_t          phase;
		logic [7:0]           word_lo;
		lz_result_t           expected_bytes [$];
		int                   errors;

		function new();
			restart_parser();
			word_lo = 8'h00;
			errors = 0;
		endfunction

		// The history is kept across a restart; only the parser and counters are cleared.
		function void restart_parser();
			hdr_pos = HDR_SIZE_LO;
			phase = ST_HEADER;
			out_count = '0;
			size_goal = '0;
			raw_on = 1'b0;
			flag_pos = 5'd16;
			flag_mask = 16'h0000;
			wr_ptr = '0;
		endfunction

		function void push_byte(logic [7:0] v);
			lz_result_t entry;
			window_mem[wr_ptr] = v;
			wr_ptr++;
			if (out_count != COUNT_MAX)
				out_count++;
			entry = '{data: v, last: 1'b0, done: 1'b0};
			expected_bytes.insert(expected_bytes.size(), entry);
		endfunction

		function void end_token();
			flag_pos++;
			phase = (flag_pos >= 5'd16) ? ST_MASK_LO : ST_TOKEN;
			if (out_count >= size_goal) begin
				phase = ST_DONE;
				expected_bytes[expected_bytes.size() - 1].done = 1'b1;
			end
		endfunction

		function void note_item(logic [7:0] b, logic mark);
			int prior_count;
			int ref_dist;
			int span;
			logic [15:0] word;
			logic [7:0] v;
			prior_count = expected_bytes.size();
			if (mark)
				restart_parser();
			case (phase)
				ST_HEADER: begin
					case (hdr_pos)
						HDR_SIZE_LO: size_goal = {16'd0, b};
						HDR_SIZE_MID: size_goal[15:8] = b;
						HDR_SIZE_HI: size_goal[23:16] = b;
						HDR_MODE: begin
							raw_on = b[RAW_BIT];
							flag_pos = 5'd16;
							phase = raw_on ? ST_RAW : ST_MASK_LO;
						end
						default: ;
					endcase
					hdr_pos++;
				end
				ST_RAW: push_byte(b);
				ST_MASK_LO: begin
					flag_mask = {8'h00, b};
					phase = ST_MASK_HI;
				end
				ST_MASK_HI: begin
					flag_mask[15:8] = b;
					flag_pos = 5'd0;
					phase = ST_TOKEN;
				end
				ST_TOKEN: begin
					if (!flag_mask[flag_pos[3:0]]) begin
						push_byte(b);
						end_token();
					end else begin
						word_lo = b;
						phase = ST_REF_HI;
					end
				end
				ST_REF_HI: begin
					word = {b, word_lo};
					ref_dist = int'((word & DIST_MASK) >> 4) + 1;
					span = int'(word & LEN_MASK) + int'(LEN_BIAS);
					// A source before the first byte of the block reads as zero.
					for (int k = 0; k < span; k++) begin
						v = 8'h00;
						if (out_count >= ref_dist)
							v = window_mem[(int'(wr_ptr) + WINDOW_DEPTH_DEF - ref_dist)
								% WINDOW_DEPTH_DEF];
						push_byte(v);
					end
					end_token();
				end
				default: ;
			endcase
			if (expected_bytes.size() > prior_count)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH: %s", what);
			errors++;
		endtask

		task check_byte(logic [7:0] data, logic last, logic done);
			lz_result_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h last %0b done %0b arrived with none expected",
					data, last, done));
				return;
			end
			want = expected_bytes.pop_front();
			if (want.data !== data || want.last !== last || want.done !== done)
				report_mismatch($sformatf("got byte %02h last %0b done %0b, expected %02h %0b %0b",
					data, last, done, want.data, want.last, want.done));
		endtask
	endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the block LZ decompressor core.
module testbench;
	import blzd_pkg::*;
	import blzd_scoreboard_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 500;
	localparam int RANDOM_ITEMS = 80;
	localparam int IDLE_PCT [4] = '{0, 76, 0, 26};
	localparam int STALL_PCT [4] = '{0, 0, 76, 26};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       start_block = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       block_done;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_wanted = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;
	lz_byte_scoreboard board;

	block_lz_decompressor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.start_block(start_block),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.block_done(block_done)
	);

	always #6 clk = ~clk;

	// Accepted items and bytes are taken at the rising edge; the watchdog counts quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_item(in_byte, start_block);
			if (out_valid && out_ready)
				board.check_byte(out_byte, last_of_run, block_done);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Receiver: random stalls, and one long hold-off when asked for.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic mark, input bit counted);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		start_block <= mark;
		do @(posedge clk); while (!in_ready);
		if (counted)
			items_sent++;
	endtask

	// Sends a header, then tokens till the size or budget is reached (raw mode: raw bytes).
	task automatic send_lz_block(input logic mark, input logic [23:0] goal,
			input logic [7:0] mode, input int budget, input int ref_pct);
		int made;
		int tokens;
		int ref_dist;
		int span;
		int lim;
		bit ended;
		logic [15:0] flags;
		logic [15:0] word;
		made = 0;
		tokens = 0;
		ended = 1'b0;
		send_item(goal[7:0], mark, 1'b1);
		send_item(goal[15:8], 1'b0, 1'b1);
		send_item(goal[23:16], 1'b0, 1'b1);
		send_item(mode, 1'b0, 1'b1);
		if (mode[RAW_BIT]) begin
			repeat (budget) send_item(8'($urandom), 1'b0, 1'b1);
			return;
		end
		while (!ended && tokens < budget) begin
			for (int i = 0; i < 16; i++)
				flags[i] = ($urandom_range(99) < ref_pct);
			send_item(flags[7:0], 1'b0, 1'b1);
			send_item(flags[15:8], 1'b0, 1'b1);
			for (int i = 0; i < 16 && !ended && tokens < budget; i++) begin
				if (!flags[i]) begin
					send_item(8'($urandom), 1'b0, 1'b1);
					made++;
				end else begin
					span = $urandom_range(3, 18);
					// Mostly distances inside the block, often short enough to overlap.
					if (made > 0 && $urandom_range(9) < 8) begin
						lim = (made < WINDOW_DEPTH_DEF) ? made : WINDOW_DEPTH_DEF;
						if ($urandom_range(1) && lim > 4)
							lim = 4;
						ref_dist = $urandom_range(1, lim);
					end else begin
						ref_dist = $urandom_range(1, WINDOW_DEPTH_DEF);
					end
					word = {12'(ref_dist - 1), 4'(span - 3)};
					send_item(word[7:0], 1'b0, 1'b1);
					send_item(word[15:8], 1'b0, 1'b1);
					made += span;
				end
				tokens++;
				ended = (made >= goal);
			end
		end
		if (ended)
			repeat ($urandom_range(2)) send_item(8'($urandom), 1'b0, 1'b0);
	endtask

	initial begin
		int phase_end;
		int pick;
		int sel;
		logic [23:0] goal;
		board = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// No start mark after reset: the first four items are still taken as the header.
		send_item(8'h05, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h02, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		// Distance one, length eighteen: an overlapping copy that overshoots the size.
		send_item(8'h0F, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hAA, 1'b0, 1'b0);
		// Raw pass-through with the largest declared size.
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h80, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		// Declared size zero, with a reference reaching before the start of the block.
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h7F, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'hF0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = IDLE_PCT[ph];
			recv_stall_pct = STALL_PCT[ph];
			phase_end = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				sel = $urandom_range(9);
				goal = (sel == 0) ? 24'd0 :
					(sel == 1) ? 24'($urandom) : 24'($urandom_range(1, 48));
				if (pick < 55) begin
					send_lz_block(1'b1, goal, {1'b0, 7'($urandom)}, $urandom_range(4, 24), 50);
				end else if (pick < 70) begin
					send_lz_block(1'b1, goal, {1'b1, 7'($urandom)}, $urandom_range(1, 12), 0);
				end else if (pick < 85) begin
					// Broken block: cut off early, sometimes in the middle of a token.
					send_lz_block(1'b1, COUNT_MAX, 8'h00, $urandom_range(1, 3), 50);
					if ($urandom_range(1))
						send_item(8'($urandom), 1'b0, 1'b1);
				end else begin
					repeat ($urandom_range(1, 6))
						send_item(8'($urandom), ($urandom_range(7) == 0), 1'b1);
				end
			end
		end

		// Long receiver hold-off while a reference-heavy block keeps arriving.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_wanted = 1'b1;
		send_lz_block(1'b1, COUNT_MAX, 8'h00, 8, 95);

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
